FILE: hw/rtl/irnb_pkg.sv
// Shared types and constants of the image resizer.
package irnb_pkg;

  localparam int unsigned MAX_SRC_DIM = 256;
  localparam int unsigned MAX_DST_DIM = 1024;
  localparam int unsigned PIXEL_BITS  = 8;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned SDIM_W  = 9;
  localparam int unsigned DDIM_W  = 11;
  localparam int unsigned SAW     = $clog2(MAX_SRC_DIM);
  localparam int unsigned PROD_W  = COORD_W + 1 + SDIM_W;
  localparam int unsigned DIV_W   = PROD_W + FRAC_BITS;
  localparam int unsigned VI_W    = PIXEL_BITS + FRAC_BITS;

  typedef enum logic [2:0] {
    REG_SRC_W  = 3'd0,
    REG_SRC_H  = 3'd1,
    REG_DST_W  = 3'd2,
    REG_DST_H  = 3'd3,
    REG_METHOD = 3'd4,
    REG_GAIN   = 3'd5,
    REG_OFFSET = 3'd6
  } reg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic {
    METHOD_NEAREST  = 1'b0,
    METHOD_BILINEAR = 1'b1
  } method_e;

  typedef struct packed {
    kind_e                 kind;
    logic [COORD_W-1:0]    cx;
    logic [COORD_W-1:0]    cy;
    logic [PIXEL_BITS-1:0] pix;
  } pl_t;

endpackage

FILE: hw/rtl/irnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module irnb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/irnb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module irnb_div #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o
);

  logic [VW-1:0] rem_q [DW];
  logic [DW-1:0] dvd_q [DW];
  logic [DW-1:0] quo_q [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] dvd_in;
    logic [DW-1:0] quo_in;
    logic [VW:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign dvd_in = dvd_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign trial = {rem_in, dvd_in[DW-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[i] <= {dvd_in[DW-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          rem_q[i] <= VW'(trial - {1'b0, divisor_i});
          quo_q[i] <= {quo_in[DW-2:0], 1'b1};
        end else begin
          rem_q[i] <= trial[VW-1:0];
          quo_q[i] <= {quo_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient_o = quo_q[DW-1];

endmodule

FILE: hw/rtl/image_resize_nearest_bilinear.sv
// Top level: frame-store image resizer, nearest or bilinear, with gain and offset.
//
// Requests enter on the s_axis channel. tuser = 0 loads pixel_in into the
// frame store at (coord_x, coord_y); tuser = 1 queries destination pixel
// (coord_x, coord_y) and yields one result on m_axis with the coordinates
// echoed. Loads give no result. A query sees every load that was accepted
// before it.
// Throughput: one request per cycle unless the receiver stalls, set by the
// 36-stage pipelined coordinate dividers and four frame store copies read in
// parallel. Each request passes stage A, the dividers and stages B to G in turn.
// The whole pipeline advances only when the output register is empty or
// taken, so a stalled receiver holds every stage; s_axis_tready drops.
// Reset clears the pipeline valids and loads the register defaults; the
// frame store is not cleared and must be loaded before it is queried.
// Registers (APB, byte address 4*i): src_width, src_height, dst_width,
// dst_height, method, gain, offset. Users write them only while the block is idle; unchecked.
module image_resize_nearest_bilinear
  import irnb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // coord_x[9:0], coord_y[19:10], pixel_in[27:20]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_out[7:0], out_x[17:8], out_y[27:18]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // config registers
  logic [SDIM_W-1:0]  src_w_q, src_h_q;
  logic [DDIM_W-1:0]  dst_w_q, dst_h_q;
  method_e            method_q;
  logic signed [15:0] gain_q, off_q;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SDIM_W'(256);
      src_h_q  <= SDIM_W'(256);
      dst_w_q  <= DDIM_W'(256);
      dst_h_q  <= DDIM_W'(256);
      method_q <= METHOD_BILINEAR;
      gain_q   <= 16'sd256;
      off_q    <= 16'sd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SRC_W:  src_w_q  <= pwdata[SDIM_W-1:0];
        REG_SRC_H:  src_h_q  <= pwdata[SDIM_W-1:0];
        REG_DST_W:  dst_w_q  <= pwdata[DDIM_W-1:0];
        REG_DST_H:  dst_h_q  <= pwdata[DDIM_W-1:0];
        REG_METHOD: method_q <= method_e'(pwdata[0]);
        REG_GAIN:   gain_q   <= pwdata[15:0];
        REG_OFFSET: off_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_W:  prdata = {{(32-SDIM_W){1'b0}}, src_w_q};
      REG_SRC_H:  prdata = {{(32-SDIM_W){1'b0}}, src_h_q};
      REG_DST_W:  prdata = {{(32-DDIM_W){1'b0}}, dst_w_q};
      REG_DST_H:  prdata = {{(32-DDIM_W){1'b0}}, dst_h_q};
      REG_METHOD: prdata = {31'd0, method_q};
      REG_GAIN:   prdata = {16'd0, gain_q};
      REG_OFFSET: prdata = {16'd0, off_q};
      default:    prdata = '0;
    endcase
  end

  // effective dimensions
  logic [SDIM_W-1:0] sw, sh;
  logic [DDIM_W-1:0] dw, dh;

  assign sw = (src_w_q == '0) ? SDIM_W'(1) :
              (src_w_q > SDIM_W'(MAX_SRC_DIM)) ? SDIM_W'(MAX_SRC_DIM) : src_w_q;
  assign sh = (src_h_q == '0) ? SDIM_W'(1) :
              (src_h_q > SDIM_W'(MAX_SRC_DIM)) ? SDIM_W'(MAX_SRC_DIM) : src_h_q;
  assign dw = (dst_w_q == '0) ? DDIM_W'(1) :
              (dst_w_q > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_w_q;
  assign dh = (dst_h_q == '0) ? DDIM_W'(1) :
              (dst_h_q > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_h_q;

  logic en;
  logic o_vld_q;

  assign en            = !o_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage A: input capture and coordinate products
  pl_t               in_pl;
  logic [PROD_W-1:0] px_d, hpx_d, py_d, hpy_d;
  logic              a_vld_q;
  pl_t               a_pl_q;
  logic [PROD_W-1:0] px_q, hpx_q, py_q, hpy_q;

  assign in_pl.kind = kind_e'(s_axis_tuser);
  assign in_pl.cx   = s_axis_tdata[9:0];
  assign in_pl.cy   = s_axis_tdata[19:10];
  assign in_pl.pix  = s_axis_tdata[27:20];

  assign px_d  = PROD_W'(in_pl.cx) * PROD_W'(sw);
  assign hpx_d = (PROD_W'(in_pl.cx) + PROD_W'(1)) * PROD_W'(sw);
  assign py_d  = PROD_W'(in_pl.cy) * PROD_W'(sh);
  assign hpy_d = (PROD_W'(in_pl.cy) + PROD_W'(1)) * PROD_W'(sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pl_q <= in_pl;
      px_q   <= px_d;
      hpx_q  <= hpx_d;
      py_q   <= py_d;
      hpy_q  <= hpy_d;
    end
  end

  // divider stages
  logic [DIV_W-1:0] qx, hx, qy, hy;

  irnb_div #(.DW(DIV_W), .VW(DDIM_W)) u_div_qx (
    .clk_i, .en_i(en), .dividend_i({px_q, {FRAC_BITS{1'b0}}}),
    .divisor_i(dw), .quotient_o(qx)
  );
  irnb_div #(.DW(DIV_W), .VW(DDIM_W)) u_div_hx (
    .clk_i, .en_i(en), .dividend_i({{FRAC_BITS{1'b0}}, hpx_q}),
    .divisor_i(dw), .quotient_o(hx)
  );
  irnb_div #(.DW(DIV_W), .VW(DDIM_W)) u_div_qy (
    .clk_i, .en_i(en), .dividend_i({py_q, {FRAC_BITS{1'b0}}}),
    .divisor_i(dh), .quotient_o(qy)
  );
  irnb_div #(.DW(DIV_W), .VW(DDIM_W)) u_div_hy (
    .clk_i, .en_i(en), .dividend_i({{FRAC_BITS{1'b0}}, hpy_q}),
    .divisor_i(dh), .quotient_o(hy)
  );

  logic dl_vld_q [DIV_W];
  pl_t  dl_pl_q  [DIV_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_W; i++) begin
        dl_vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld_q[0] <= a_vld_q;
      for (int i = 1; i < DIV_W; i++) begin
        dl_vld_q[i] <= dl_vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_pl_q[0] <= a_pl_q;
      for (int i = 1; i < DIV_W; i++) begin
        dl_pl_q[i] <= dl_pl_q[i-1];
      end
    end
  end

  // stage B: clamp coordinates
  logic [SDIM_W-1:0]    swm1, shm1;
  logic [SAW-1:0]       xl_d, xh_d, yl_d, yh_d;
  logic [FRAC_BITS-1:0] fx_d, fy_d;
  logic                 b_vld_q;
  pl_t                  b_pl_q;
  logic [SAW-1:0]       b_xl_q, b_xh_q, b_yl_q, b_yh_q;
  logic [FRAC_BITS-1:0] b_fx_q, b_fy_q;

  assign swm1 = sw - SDIM_W'(1);
  assign shm1 = sh - SDIM_W'(1);

  always_comb begin
    if (qx[DIV_W-1:FRAC_BITS] > PROD_W'(swm1)) begin
      xl_d = swm1[SAW-1:0];
      fx_d = '0;
    end else begin
      xl_d = qx[FRAC_BITS +: SAW];
      fx_d = qx[FRAC_BITS-1:0];
    end
    if (qy[DIV_W-1:FRAC_BITS] > PROD_W'(shm1)) begin
      yl_d = shm1[SAW-1:0];
      fy_d = '0;
    end else begin
      yl_d = qy[FRAC_BITS +: SAW];
      fy_d = qy[FRAC_BITS-1:0];
    end
    xh_d = (hx > DIV_W'(swm1)) ? swm1[SAW-1:0] : hx[SAW-1:0];
    yh_d = (hy > DIV_W'(shm1)) ? shm1[SAW-1:0] : hy[SAW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= dl_vld_q[DIV_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_pl_q <= dl_pl_q[DIV_W-1];
      b_xl_q <= xl_d;
      b_xh_q <= xh_d;
      b_yl_q <= yl_d;
      b_yh_q <= yh_d;
      b_fx_q <= fx_d;
      b_fy_q <= fy_d;
    end
  end

  // stage C: frame store, one copy per bilinear tap
  logic                  st_we;
  logic [2*SAW-1:0]      st_waddr;
  logic [PIXEL_BITS-1:0] p00, p10, p01, p11;

  assign st_we = en && b_vld_q && (b_pl_q.kind == KIND_LOAD) &&
                 (b_pl_q.cx < COORD_W'(MAX_SRC_DIM)) &&
                 (b_pl_q.cy < COORD_W'(MAX_SRC_DIM));
  assign st_waddr = {b_pl_q.cy[SAW-1:0], b_pl_q.cx[SAW-1:0]};

  irnb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SRC_DIM*MAX_SRC_DIM)) u_ram00 (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(b_pl_q.pix),
    .re_i(en), .raddr_i({b_yl_q, b_xl_q}), .rdata_o(p00)
  );
  irnb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SRC_DIM*MAX_SRC_DIM)) u_ram10 (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(b_pl_q.pix),
    .re_i(en), .raddr_i({b_yl_q, b_xh_q}), .rdata_o(p10)
  );
  irnb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SRC_DIM*MAX_SRC_DIM)) u_ram01 (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(b_pl_q.pix),
    .re_i(en), .raddr_i({b_yh_q, b_xl_q}), .rdata_o(p01)
  );
  irnb_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_SRC_DIM*MAX_SRC_DIM)) u_ram11 (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(b_pl_q.pix),
    .re_i(en), .raddr_i({b_yh_q, b_xh_q}), .rdata_o(p11)
  );

  logic                 c_vld_q;
  logic [COORD_W-1:0]   c_cx_q, c_cy_q;
  logic [FRAC_BITS-1:0] c_fx_q, c_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q && (b_pl_q.kind == KIND_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_cx_q <= b_pl_q.cx;
      c_cy_q <= b_pl_q.cy;
      c_fx_q <= b_fx_q;
      c_fy_q <= b_fy_q;
    end
  end

  // stage D: horizontal blend
  localparam int unsigned ROW_W = VI_W + 1;
  logic [FRAC_BITS:0]    wlx;
  logic [ROW_W-1:0]      top_d, bot_d;
  logic                  d_vld_q;
  logic [COORD_W-1:0]    d_cx_q, d_cy_q;
  logic [FRAC_BITS-1:0]  d_fy_q;
  logic [ROW_W-1:0]      d_top_q, d_bot_q;
  logic [PIXEL_BITS-1:0] d_p00_q;

  assign wlx   = ONE - (FRAC_BITS+1)'(c_fx_q);
  assign top_d = ROW_W'(wlx) * ROW_W'(p00) + ROW_W'(c_fx_q) * ROW_W'(p10);
  assign bot_d = ROW_W'(wlx) * ROW_W'(p01) + ROW_W'(c_fx_q) * ROW_W'(p11);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_cx_q  <= c_cx_q;
      d_cy_q  <= c_cy_q;
      d_fy_q  <= c_fy_q;
      d_top_q <= top_d;
      d_bot_q <= bot_d;
      d_p00_q <= p00;
    end
  end

  // stage E: vertical blend or nearest pick
  localparam int unsigned V_W = ROW_W + FRAC_BITS + 1;
  logic [FRAC_BITS:0] wly;
  logic [V_W-1:0]     v_d;
  logic [VI_W-1:0]    vi_d;
  logic               e_vld_q;
  logic [COORD_W-1:0] e_cx_q, e_cy_q;
  logic [VI_W-1:0]    e_vi_q;

  assign wly  = ONE - (FRAC_BITS+1)'(d_fy_q);
  assign v_d  = V_W'(wly) * V_W'(d_top_q) + V_W'(d_fy_q) * V_W'(d_bot_q);
  assign vi_d = (method_q == METHOD_NEAREST) ? {d_p00_q, {FRAC_BITS{1'b0}}}
                                             : v_d[FRAC_BITS +: VI_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_cx_q <= d_cx_q;
      e_cy_q <= d_cy_q;
      e_vi_q <= vi_d;
    end
  end

  // stage F: gain and offset
  localparam int unsigned ACC_W = VI_W + 18;
  logic signed [ACC_W-1:0] off_ext, acc_d;
  logic                    f_vld_q;
  logic [COORD_W-1:0]      f_cx_q, f_cy_q;
  logic signed [ACC_W-1:0] f_acc_q;

  assign off_ext = $signed({{(ACC_W-16-FRAC_BITS){off_q[15]}}, off_q, {FRAC_BITS{1'b0}}});
  assign acc_d   = $signed({1'b0, e_vi_q}) * gain_q + off_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_cx_q  <= e_cx_q;
      f_cy_q  <= e_cy_q;
      f_acc_q <= acc_d;
    end
  end

  // stage G: saturate into the output register
  localparam int unsigned RS = FRAC_BITS + 8;
  logic [PIXEL_BITS-1:0] pix_d;
  logic [PIXEL_BITS-1:0] o_pix_q;
  logic [COORD_W-1:0]    o_x_q, o_y_q;

  always_comb begin
    if (f_acc_q[ACC_W-1]) begin
      pix_d = '0;
    end else if (f_acc_q[ACC_W-2:RS] > (ACC_W-1-RS)'({PIXEL_BITS{1'b1}})) begin
      pix_d = {PIXEL_BITS{1'b1}};
    end else begin
      pix_d = f_acc_q[RS +: PIXEL_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_pix_q <= pix_d;
      o_x_q   <= f_cx_q;
      o_y_q   <= f_cy_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {4'd0, o_y_q, o_x_q, o_pix_q};

endmodule

FILE: tb/image_resize_nearest_bilinear_tb.sv
// Testbench for the image resizer: directed and randomized loads and queries checked against a predictor.
`timescale 1ns / 100ps

module image_resize_nearest_bilinear_tb;
  import irnb_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] pix;
  } req_t;

  typedef struct {
    logic [7:0] pix;
    logic [9:0] x;
    logic [9:0] y;
  } pixel_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // coord_x[9:0], coord_y[19:10], pixel_in[27:20]
  logic        s_axis_tuser = 1'b0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // pixel_out[7:0], out_x[17:8], out_y[27:18]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  image_resize_nearest_bilinear DUT (.*);

  // config shadow, raw register values
  logic [8:0]  cfg_sw = 9'd256, cfg_sh = 9'd256;
  logic [10:0] cfg_dw = 11'd256, cfg_dh = 11'd256;
  method_e     cfg_method = METHOD_BILINEAR;
  logic [15:0] cfg_gain = 16'd256, cfg_offset = 16'd0;

  logic [7:0]  frame_mem [65536];
  bit          gen_written [65536];
  req_t        pending_reqs[$];
  pixel_res_t  expected_pixels[$];
  req_t        cur_req, nxt_req;
  int          send_idle = 0, recv_idle = 0;
  bit          failed = 0;
  int          stall_cnt = 0;
  int          item_cnt = 0;

  initial forever #6 clk_i = ~clk_i;

  function automatic logic [15:0] addr_of(int unsigned x, int unsigned y);
    return {y[7:0], x[7:0]};
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void axis_span(input int unsigned c, input int unsigned s,
                                    input int unsigned d, output int unsigned lo,
                                    output int unsigned hi, output longint unsigned fr);
    longint unsigned q, l, h;
    q  = ((longint'(c) * s) << FRAC_BITS) / d;
    l  = q >> FRAC_BITS;
    h  = (longint'(c + 1) * s) / d;
    fr = q & 64'hFFFF;
    if (l > s - 1) begin
      l  = s - 1;
      fr = 0;
    end
    if (h > s - 1) h = s - 1;
    lo = 32'(l);
    hi = 32'(h);
  endfunction

  function automatic void query_spans(input logic [9:0] x, input logic [9:0] y,
                                      output int unsigned xl, output int unsigned xh,
                                      output longint unsigned fx, output int unsigned yl,
                                      output int unsigned yh, output longint unsigned fy);
    axis_span({22'd0, x}, clamp_dim({23'd0, cfg_sw}, MAX_SRC_DIM),
              clamp_dim({21'd0, cfg_dw}, MAX_DST_DIM), xl, xh, fx);
    axis_span({22'd0, y}, clamp_dim({23'd0, cfg_sh}, MAX_SRC_DIM),
              clamp_dim({21'd0, cfg_dh}, MAX_DST_DIM), yl, yh, fy);
  endfunction

  function automatic logic [7:0] resize_pixel(logic [9:0] x, logic [9:0] y);
    int unsigned xl, xh, yl, yh;
    longint unsigned fx, fy, vi, top, bot;
    longint acc, r;
    query_spans(x, y, xl, xh, fx, yl, yh, fy);
    if (cfg_method == METHOD_NEAREST) begin
      vi = longint'(frame_mem[addr_of(xl, yl)]) << FRAC_BITS;
    end else begin
      top = (65536 - fx) * frame_mem[addr_of(xl, yl)] + fx * frame_mem[addr_of(xh, yl)];
      bot = (65536 - fx) * frame_mem[addr_of(xl, yh)] + fx * frame_mem[addr_of(xh, yh)];
      vi  = ((65536 - fy) * top + fy * bot) >> FRAC_BITS;
    end
    acc = longint'(vi) * longint'($signed(cfg_gain))
        + longint'($signed(cfg_offset)) * 65536;
    if (acc < 0) return 8'd0;
    r = acc >>> 24;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  task automatic apply_request(req_t r);
    pixel_res_t e;
    if (r.kind == KIND_LOAD) begin
      if (r.x < 256 && r.y < 256) frame_mem[addr_of({22'd0, r.x}, {22'd0, r.y})] = r.pix;
    end else begin
      e.pix = resize_pixel(r.x, r.y);
      e.x   = r.x;
      e.y   = r.y;
      expected_pixels.insert(expected_pixels.size(), e);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_request(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt_req = pending_reqs.pop_front();
          cur_req <= nxt_req;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt_req.kind;
          s_axis_tdata <= {4'b0, nxt_req.pix, nxt_req.y, nxt_req.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
          failed = 1;
        end else begin : chk
          pixel_res_t e;
          e = expected_pixels.pop_front();
          if (m_axis_tdata[7:0] !== e.pix || m_axis_tdata[17:8] !== e.x ||
              m_axis_tdata[27:18] !== e.y) begin
            $display("%0t mismatch: expected pix %0d x %0d y %0d, actual pix %0d x %0d y %0d",
                     $time, e.pix, e.x, e.y, m_axis_tdata[7:0], m_axis_tdata[17:8],
                     m_axis_tdata[27:18]);
            failed = 1;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_W:  cfg_sw = val[8:0];
      REG_SRC_H:  cfg_sh = val[8:0];
      REG_DST_W:  cfg_dw = val[10:0];
      REG_DST_H:  cfg_dh = val[10:0];
      REG_METHOD: cfg_method = method_e'(val[0]);
      REG_GAIN:   cfg_gain = val[15:0];
      REG_OFFSET: cfg_offset = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int sw, int sh, int dw, int dh, method_e m, int g, int o);
    apb_write(REG_SRC_W, sw);
    apb_write(REG_SRC_H, sh);
    apb_write(REG_DST_W, dw);
    apb_write(REG_DST_H, dh);
    apb_write(REG_METHOD, {31'd0, m});
    apb_write(REG_GAIN, g & 16'hFFFF);
    apb_write(REG_OFFSET, o & 16'hFFFF);
  endtask

  task automatic add_load(int x, int y, int p);
    req_t r;
    r.kind = KIND_LOAD;
    r.x = 10'(x);
    r.y = 10'(y);
    r.pix = 8'(p);
    pending_reqs.insert(pending_reqs.size(), r);
    item_cnt++;
    if (x < 256 && y < 256) gen_written[addr_of(x, y)] = 1;
  endtask

  // loads any pixel the query would read that has not been written yet
  task automatic add_query(int x, int y);
    int unsigned xl, xh, yl, yh;
    longint unsigned fx, fy;
    req_t r;
    query_spans(10'(x), 10'(y), xl, xh, fx, yl, yh, fy);
    if (!gen_written[addr_of(xl, yl)]) add_load(xl, yl, $urandom_range(0, 255));
    if (!gen_written[addr_of(xh, yl)]) add_load(xh, yl, $urandom_range(0, 255));
    if (!gen_written[addr_of(xl, yh)]) add_load(xl, yh, $urandom_range(0, 255));
    if (!gen_written[addr_of(xh, yh)]) add_load(xh, yh, $urandom_range(0, 255));
    r.kind = KIND_QUERY;
    r.x = 10'(x);
    r.y = 10'(y);
    r.pix = 8'($urandom_range(0, 255));
    pending_reqs.insert(pending_reqs.size(), r);
    item_cnt++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(negedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int dw, dh, sw, sh;
    sw = clamp_dim({23'd0, cfg_sw}, MAX_SRC_DIM);
    sh = clamp_dim({23'd0, cfg_sh}, MAX_SRC_DIM);
    dw = clamp_dim({21'd0, cfg_dw}, MAX_DST_DIM);
    dh = clamp_dim({21'd0, cfg_dh}, MAX_DST_DIM);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: add_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255));
        1, 2: add_load($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                       $urandom_range(0, 255));
        3: add_query($urandom_range(0, 1023), $urandom_range(0, 1023));
        default: add_query($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
      endcase
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration
    send_idle = 37;
    recv_idle = 79;
    add_load(0, 0, 0);
    add_load(255, 255, 255);
    add_load(255, 0, 8'hAA);
    add_load(0, 255, 8'h55);
    add_load(1023, 1023, 8'hFF);
    add_load(300, 5, 8'h11);
    add_query(0, 0);
    add_query(255, 255);
    add_query(128, 127);
    add_query(1023, 1023);
    add_query(1023, 0);
    wait_idle();

    send_idle = 79;
    recv_idle = 37;
    set_config(1, 1, 1, 1, METHOD_NEAREST, 256, 0);
    add_query(0, 0);
    add_query(1023, 1023);
    random_phase(20);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    set_config(256, 256, 1024, 1024, METHOD_BILINEAR, 32767, -32768);
    add_query(0, 0);
    add_query(1023, 1023);
    add_query(511, 3);
    random_phase(40);
    wait_idle();

    set_config(0, 511, 0, 2047, METHOD_NEAREST, -32768, 32767);
    add_query(0, 1023);
    add_query(5, 700);
    random_phase(30);
    wait_idle();

    phase = 0;
    while (item_cnt < 1850) begin
      send_idle = (phase % 3 == 0) ? 37 : (phase % 3 == 1) ? 79 : 0;
      recv_idle = (phase % 3 == 0) ? 79 : (phase % 3 == 1) ? 37 : 0;
      set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 16),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 16),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 40),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 40),
                 method_e'($urandom_range(0, 1)),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 600),
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 4000) - 2000);
      random_phase(150);
      wait_idle();
      phase++;
    end

    if (!failed)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/irnb_pkg.sv
hw/rtl/irnb_ram.sv
hw/rtl/irnb_div.sv
hw/rtl/image_resize_nearest_bilinear.sv
tb/image_resize_nearest_bilinear_tb.sv
